// ===== design/sfr_pkg.sv =====
// sfr_pkg: shared types and constants for the sensor frame receiver
// no dependencies; used by every module of the block by scoped names

package sfr_pkg;

   localparam int FRAME_LEN = 24;
   localparam int CHECK_POS = 22;
   localparam int LAST_POS  = 23;
   localparam int POS_W     = 5;

   localparam logic [POS_W-1:0] POS_FIRST = POS_W'(0);
   localparam logic [POS_W-1:0] POS_CHECK = POS_W'(CHECK_POS);
   localparam logic [POS_W-1:0] POS_TAIL  = POS_W'(LAST_POS);

   // configuration register indexes
   localparam logic [7:0] CSR_HEADER = 8'd0;
   localparam logic [7:0] CSR_TAIL   = 8'd1;

   localparam logic [7:0] HEADER_RESET = 8'd123;
   localparam logic [7:0] TAIL_RESET   = 8'd125;

   // one classified frame byte on its way from front to back
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic [7:0]       data;
   } beat_type;

   // unpacked result of one good frame
   typedef struct packed {
      logic [7:0]         stop_flag;
      logic signed [15:0] vel_x_mm;
      logic signed [15:0] vel_y_mm;
      logic signed [15:0] vel_z_mrad;
      logic signed [15:0] accel_x_raw;
      logic signed [15:0] accel_y_raw;
      logic signed [15:0] accel_z_raw;
      logic signed [15:0] gyro_x_raw;
      logic signed [15:0] gyro_y_raw;
      logic signed [15:0] gyro_z_raw;
      logic signed [15:0] battery_mv;
   } result_type;

endpackage

// ===== design/sfr_front.sv =====
// sfr_front: accepts received bytes, hunts for the header and tags each
// frame byte with its position; depends on sfr_pkg

module sfr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  logic [7:0]           header_byte,
   input  logic                 q_full,
   output logic                 q_push,
   output sfr_pkg::beat_type    q_beat
);

   logic [sfr_pkg::POS_W-1:0] count_ff, count_in;
   logic                      accept;
   logic                      in_frame;
   logic                      is_header;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign in_frame  = (count_ff != sfr_pkg::POS_FIRST);
   assign is_header = (req_rx_byte == header_byte);

   // bytes outside a frame that are not the header are dropped here
   assign q_push      = accept && (in_frame || is_header);
   assign q_beat.pos  = count_ff;
   assign q_beat.data = req_rx_byte;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (!in_frame) begin
            count_in = is_header ? sfr_pkg::POS_W'(1) : sfr_pkg::POS_FIRST;
         end else if (count_ff == sfr_pkg::POS_TAIL) begin
            count_in = sfr_pkg::POS_FIRST;
         end else begin
            count_in = count_ff + sfr_pkg::POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= sfr_pkg::POS_FIRST;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/sfr_queue.sv =====
// sfr_queue: small first-in first-out buffer of tagged frame bytes
// between front and back; depends on sfr_pkg

module sfr_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfr_pkg::beat_type push_beat,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output sfr_pkg::beat_type pop_beat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sfr_pkg::beat_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign not_empty = (fill_ff != CNT_W'(0));
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_beat  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== design/sfr_back.sv =====
// sfr_back: assembles frame bytes, runs the xor block check and tail check,
// and holds the unpacked result for the output; depends on sfr_pkg

module sfr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  sfr_pkg::beat_type  q_beat,
   output logic               q_pop,
   input  logic [7:0]         tail_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sfr_pkg::result_type rsp_result
);

   logic [7:0]          data_ff [1:sfr_pkg::CHECK_POS-1];
   logic [7:0]          xor_ff, xor_in;
   logic                check_ok_ff, check_ok_in;
   logic                valid_ff, valid_in;
   sfr_pkg::result_type result_ff, result_in;
   logic                out_free;
   logic                is_tail;
   logic                frame_good;

   assign out_free   = !valid_ff || rsp_ready;
   assign is_tail    = (q_beat.pos == sfr_pkg::POS_TAIL);
   // the tail byte waits in the queue until the output slot can take it
   assign q_pop      = q_not_empty && (!is_tail || out_free);
   assign frame_good = check_ok_ff && (q_beat.data == tail_byte);

   always_comb begin
      xor_in      = xor_ff;
      check_ok_in = check_ok_ff;
      if (q_pop) begin
         if (q_beat.pos == sfr_pkg::POS_FIRST) begin
            xor_in = q_beat.data;
         end else if (q_beat.pos < sfr_pkg::POS_CHECK) begin
            xor_in = xor_ff ^ q_beat.data;
         end
         if (q_beat.pos == sfr_pkg::POS_CHECK) begin
            check_ok_in = (xor_ff == q_beat.data);
         end
      end
   end

   always_comb begin
      result_in.stop_flag   = data_ff[1];
      result_in.vel_x_mm    = {data_ff[2],  data_ff[3]};
      result_in.vel_y_mm    = {data_ff[4],  data_ff[5]};
      result_in.vel_z_mrad  = {data_ff[6],  data_ff[7]};
      result_in.accel_x_raw = {data_ff[8],  data_ff[9]};
      result_in.accel_y_raw = {data_ff[10], data_ff[11]};
      result_in.accel_z_raw = {data_ff[12], data_ff[13]};
      result_in.gyro_x_raw  = {data_ff[14], data_ff[15]};
      result_in.gyro_y_raw  = {data_ff[16], data_ff[17]};
      result_in.gyro_z_raw  = {data_ff[18], data_ff[19]};
      result_in.battery_mv  = {data_ff[20], data_ff[21]};
   end

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (q_pop && is_tail && frame_good) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int i = 1; i < sfr_pkg::CHECK_POS; i++) begin
            if (q_beat.pos == sfr_pkg::POS_W'(i)) begin
               data_ff[i] <= q_beat.data;
            end
         end
      end
      if (q_pop && is_tail && frame_good) begin
         result_ff <= result_in;
      end
      xor_ff      <= xor_in;
      check_ok_ff <= check_ok_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== design/sensor_frame_receiver.sv =====
// sensor_frame_receiver: top level of the header/tail/xor-checked frame deframer
// depends on sfr_pkg, sfr_front, sfr_queue and sfr_back

// The block takes one received byte per beat on the req_ channel and gives
// one unpacked result on the rsp_ channel for every good 24-byte frame. A
// frame opens with the header byte; that byte and the next 23 are the frame.
// It is good when byte 23 equals the tail byte and byte 22 equals the xor of
// bytes 0 to 21; bad frames vanish without a result. There is no resync
// inside a frame, so a header or tail value mid-frame is plain data. The
// input side takes one byte every cycle unless the queue is full; bytes flow
// through a short queue (QUEUE_DEPTH entries) into the checking back end,
// which also handles one byte a cycle, save that a tail byte waiting on an
// untaken result holds up the queue. A result is kept in an output register
// until taken. Header and tail registers are written through the csr_ channel
// (index 0 header, index 1 tail, others ignored); the user must write them
// only while the block is idle, which the block itself does not enforce;
// csr_ready is always high.

module sensor_frame_receiver #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   // byte input
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   // result output
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_stop_flag,
   output logic signed [15:0] rsp_vel_x_mm,
   output logic signed [15:0] rsp_vel_y_mm,
   output logic signed [15:0] rsp_vel_z_mrad,
   output logic signed [15:0] rsp_accel_x_raw,
   output logic signed [15:0] rsp_accel_y_raw,
   output logic signed [15:0] rsp_accel_z_raw,
   output logic signed [15:0] rsp_gyro_x_raw,
   output logic signed [15:0] rsp_gyro_y_raw,
   output logic signed [15:0] rsp_gyro_z_raw,
   output logic signed [15:0] rsp_battery_mv,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [7:0]         csr_data
);

   logic [7:0]          header_byte_ff, header_byte_in;
   logic [7:0]          tail_byte_ff, tail_byte_in;
   logic                csr_write;
   logic                q_push, q_full, q_pop, q_not_empty;
   sfr_pkg::beat_type   push_beat, pop_beat;
   sfr_pkg::result_type result;

   // config registers, written any cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      header_byte_in = header_byte_ff;
      tail_byte_in   = tail_byte_ff;
      if (csr_write) begin
         unique case (csr_index)
            sfr_pkg::CSR_HEADER: header_byte_in = csr_data;
            sfr_pkg::CSR_TAIL:   tail_byte_in   = csr_data;
            default: ;   // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_byte_ff <= sfr_pkg::HEADER_RESET;
         tail_byte_ff   <= sfr_pkg::TAIL_RESET;
      end else begin
         header_byte_ff <= header_byte_in;
         tail_byte_ff   <= tail_byte_in;
      end
   end

   // front: header hunt and byte position tagging
   sfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .header_byte (header_byte_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_beat      (push_beat)
   );

   // decoupling queue
   sfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_beat (push_beat),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_beat  (pop_beat)
   );

   // back: frame assembly, checks and output register
   sfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_beat      (pop_beat),
      .q_pop       (q_pop),
      .tail_byte   (tail_byte_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (result)
   );

   assign rsp_stop_flag   = result.stop_flag;
   assign rsp_vel_x_mm    = result.vel_x_mm;
   assign rsp_vel_y_mm    = result.vel_y_mm;
   assign rsp_vel_z_mrad  = result.vel_z_mrad;
   assign rsp_accel_x_raw = result.accel_x_raw;
   assign rsp_accel_y_raw = result.accel_y_raw;
   assign rsp_accel_z_raw = result.accel_z_raw;
   assign rsp_gyro_x_raw  = result.gyro_x_raw;
   assign rsp_gyro_y_raw  = result.gyro_y_raw;
   assign rsp_gyro_z_raw  = result.gyro_z_raw;
   assign rsp_battery_mv  = result.battery_mv;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for sensor_frame_receiver
// depends on sfr_pkg and the sensor_frame_receiver rtl; needs nothing else

module tb;

   // spare register index, writes to it must be dropped
   localparam logic [7:0] CSR_LAST = 8'hFF;
   // cycles to let bytes still in the queue drain when no result is pending
   localparam int DRAIN_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT = 400000;
   // random part stops once this many frame bytes have gone out
   localparam int RANDOM_BEATS = 650;
   localparam logic [7:0] DEF_HEADER = sfr_pkg::HEADER_RESET;
   localparam logic [7:0] DEF_TAIL   = sfr_pkg::TAIL_RESET;

   typedef enum logic [1:0] {
      FRAME_GOOD,
      FRAME_BAD_TAIL,
      FRAME_BAD_SUM
   } frame_kind_type;

   // one directed frame: register values, frame kind, idle bytes ahead of it,
   // and when typed the stop flag and the word repeated in every 16-bit field
   typedef struct packed {
      logic [7:0]     header;
      logic [7:0]     tail;
      frame_kind_type kind;
      logic [2:0]     noise;
      logic           typed;
      logic [7:0]     stop;
      logic [15:0]    word;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [7:0]         rsp_stop_flag;
   logic signed [15:0] rsp_vel_x_mm;
   logic signed [15:0] rsp_vel_y_mm;
   logic signed [15:0] rsp_vel_z_mrad;
   logic signed [15:0] rsp_accel_x_raw;
   logic signed [15:0] rsp_accel_y_raw;
   logic signed [15:0] rsp_accel_z_raw;
   logic signed [15:0] rsp_gyro_x_raw;
   logic signed [15:0] rsp_gyro_y_raw;
   logic signed [15:0] rsp_gyro_z_raw;
   logic signed [15:0] rsp_battery_mv;
   logic               csr_valid;
   logic               csr_ready;
   logic [7:0]         csr_index;
   logic [7:0]         csr_data;

   // mirror of the deframer state and its registers
   logic [7:0]  frame_bytes [sfr_pkg::FRAME_LEN];
   int unsigned fill_count;
   logic [7:0]  cur_header;
   logic [7:0]  cur_tail;

   // unpacked frames still owed by the block, oldest first
   sfr_pkg::result_type frame_results [$];
   sfr_pkg::result_type seen_result;
   sfr_pkg::result_type want_result;

   // frame under construction for the sender
   logic [7:0]  outgoing [sfr_pkg::FRAME_LEN];

   int unsigned miss_count = 0;
   int unsigned cycle_count = 0;
   int unsigned random_beats = 0;
   bit          source_quiet = 1'b0;
   bit          sink_quiet = 1'b0;

   // directed frames: extremes first, then the error cases, then odd register values
   directed_row_type directed_rows [11] = '{
      // all-zero payload
      '{DEF_HEADER, DEF_TAIL, FRAME_GOOD, 3'd0, 1'b1, 8'h00, 16'h0000},
      // idle junk ahead of the header is skipped, all-ones payload
      '{DEF_HEADER, DEF_TAIL, FRAME_GOOD, 3'd3, 1'b1, 8'hFF, 16'hFFFF},
      '{DEF_HEADER, DEF_TAIL, FRAME_GOOD, 3'd0, 1'b1, 8'h01, 16'h7FFF},
      '{DEF_HEADER, DEF_TAIL, FRAME_GOOD, 3'd0, 1'b1, 8'h80, 16'h8000},
      // header and tail values inside the payload are plain data
      '{DEF_HEADER, DEF_TAIL, FRAME_GOOD, 3'd0, 1'b1, DEF_TAIL,
        {DEF_HEADER, DEF_TAIL}},
      // wrong tail and wrong block check both vanish
      '{DEF_HEADER, DEF_TAIL, FRAME_BAD_TAIL, 3'd0, 1'b1, 8'h00, 16'h0000},
      '{DEF_HEADER, DEF_TAIL, FRAME_BAD_SUM, 3'd0, 1'b1, 8'h00, 16'h0000},
      // register extremes, random payloads checked by the predictor
      '{8'h00, 8'hFF, FRAME_GOOD, 3'd2, 1'b0, 8'h00, 16'h0000},
      '{8'hFF, 8'h00, FRAME_GOOD, 3'd0, 1'b0, 8'h00, 16'h0000},
      // header equal to tail
      '{8'hA5, 8'hA5, FRAME_GOOD, 3'd1, 1'b0, 8'h00, 16'h0000},
      '{8'hA5, 8'hA5, FRAME_BAD_SUM, 3'd0, 1'b1, 8'h00, 16'h0000}
   };

   sensor_frame_receiver i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_stop_flag   (rsp_stop_flag),
      .rsp_vel_x_mm    (rsp_vel_x_mm),
      .rsp_vel_y_mm    (rsp_vel_y_mm),
      .rsp_vel_z_mrad  (rsp_vel_z_mrad),
      .rsp_accel_x_raw (rsp_accel_x_raw),
      .rsp_accel_y_raw (rsp_accel_y_raw),
      .rsp_accel_z_raw (rsp_accel_z_raw),
      .rsp_gyro_x_raw  (rsp_gyro_x_raw),
      .rsp_gyro_y_raw  (rsp_gyro_y_raw),
      .rsp_gyro_z_raw  (rsp_gyro_z_raw),
      .rsp_battery_mv  (rsp_battery_mv),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("sensor_frame_receiver regression: fail");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // deframer predictor
   // -------------------------------------------------------------------------

   // takes one accepted byte; reports a result when it closes a good frame
   function automatic void take_byte(input logic [7:0] value, output bit got,
                                     output sfr_pkg::result_type unpacked);
      logic [7:0]                             xor_sum;
      logic [$bits(sfr_pkg::result_type)-1:0] packed_bytes;
      int                                     k;
      got = 1'b0;
      unpacked = '0;
      if (fill_count == 0) begin
         // idle: only the header opens a frame
         if (value == cur_header) begin
            frame_bytes[0] = value;
            fill_count = 1;
         end
      end else begin
         frame_bytes[fill_count] = value;
         fill_count++;
         if (fill_count == sfr_pkg::FRAME_LEN) begin
            fill_count = 0;
            xor_sum = 8'h00;
            for (k = 0; k < sfr_pkg::CHECK_POS; k++)
               xor_sum ^= frame_bytes[k];
            if (frame_bytes[sfr_pkg::LAST_POS] == cur_tail &&
                frame_bytes[sfr_pkg::CHECK_POS] == xor_sum) begin
               // result fields run big-endian in frame order from byte 1 on
               packed_bytes = '0;
               for (k = 1; k < sfr_pkg::CHECK_POS; k++)
                  packed_bytes = {packed_bytes[$bits(sfr_pkg::result_type)-9:0],
                                  frame_bytes[k]};
               unpacked = sfr_pkg::result_type'(packed_bytes);
               got = 1'b1;
            end
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // result checking
   // -------------------------------------------------------------------------

   task automatic log_failure(input string what);
      miss_count++;
      if (miss_count <= 10)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want)
         log_failure($sformatf("%s expected 0x%04h, got 0x%04h", name, want, got));
   endtask

   task automatic compare_result(input sfr_pkg::result_type want,
                                 input sfr_pkg::result_type got);
      check_field("stop_flag", 16'(want.stop_flag), 16'(got.stop_flag));
      check_field("vel_x_mm", want.vel_x_mm, got.vel_x_mm);
      check_field("vel_y_mm", want.vel_y_mm, got.vel_y_mm);
      check_field("vel_z_mrad", want.vel_z_mrad, got.vel_z_mrad);
      check_field("accel_x_raw", want.accel_x_raw, got.accel_x_raw);
      check_field("accel_y_raw", want.accel_y_raw, got.accel_y_raw);
      check_field("accel_z_raw", want.accel_z_raw, got.accel_z_raw);
      check_field("gyro_x_raw", want.gyro_x_raw, got.gyro_x_raw);
      check_field("gyro_y_raw", want.gyro_y_raw, got.gyro_y_raw);
      check_field("gyro_z_raw", want.gyro_z_raw, got.gyro_z_raw);
      check_field("battery_mv", want.battery_mv, got.battery_mv);
   endtask

   // every result beat is matched against the oldest owed frame
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_result = {rsp_stop_flag, rsp_vel_x_mm, rsp_vel_y_mm, rsp_vel_z_mrad,
                        rsp_accel_x_raw, rsp_accel_y_raw, rsp_accel_z_raw,
                        rsp_gyro_x_raw, rsp_gyro_y_raw, rsp_gyro_z_raw, rsp_battery_mv};
         if (frame_results.size() == 0) begin
            log_failure("result beat with no frame owed");
         end else begin
            want_result = frame_results.pop_front();
            compare_result(want_result, seen_result);
         end
      end
   end

   // result side: random stall ahead of each beat unless in a quiet stretch
   initial begin
      int unsigned stall;
      forever begin
         stall = sink_quiet ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // byte source
   // -------------------------------------------------------------------------

   // payload byte leaning toward the register values and the extremes
   function automatic logic [7:0] pick_data();
      case ($urandom_range(0, 7))
         0: return cur_header;
         1: return cur_tail;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // fills outgoing with a frame for the current registers, spoiled as asked
   function automatic void build_frame(input frame_kind_type kind, input bit scramble,
                                       input logic [7:0] stop, input logic [15:0] word);
      logic [7:0] xor_sum;
      int         k;
      outgoing[0] = cur_header;
      outgoing[1] = scramble ? pick_data() : stop;
      for (k = 2; k < sfr_pkg::CHECK_POS; k++)
         outgoing[k] = scramble ? pick_data() : ((k % 2 == 0) ? word[15:8] : word[7:0]);
      xor_sum = 8'h00;
      for (k = 0; k < sfr_pkg::CHECK_POS; k++)
         xor_sum ^= outgoing[k];
      outgoing[sfr_pkg::CHECK_POS] = (kind == FRAME_BAD_SUM) ?
                                     xor_sum ^ 8'(1 << $urandom_range(0, 7)) : xor_sum;
      outgoing[sfr_pkg::LAST_POS] = (kind == FRAME_BAD_TAIL) ?
                                    cur_tail ^ 8'($urandom_range(1, 255)) : cur_tail;
   endfunction

   // one byte beat; valid only drops when a gap is drawn, so it never
   // gets two updates in one step
   task automatic send_byte(input logic [7:0] value, input bit keep);
      int unsigned         gap;
      bit                  got;
      sfr_pkg::result_type unpacked;
      gap = source_quiet ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      take_byte(value, got, unpacked);
      if (got && keep)
         frame_results.push_back(unpacked);
   endtask

   // bytes other than the header, sent while the block should be idle
   task automatic send_noise(input int unsigned count);
      logic [7:0] value;
      repeat (count) begin
         do value = 8'($urandom_range(0, 255)); while (value == cur_header);
         send_byte(value, 1'b1);
      end
   endtask

   task automatic send_frame(input int unsigned length, input bit keep);
      int unsigned k;
      for (k = 0; k < length; k++)
         send_byte(outgoing[k], keep);
   endtask

   // hold the source until every owed frame has come out
   task automatic wait_results_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_results.size() != 0) @(posedge clock);
   endtask

   // close any open frame, then let the block empty out
   task automatic settle();
      while (fill_count != 0)
         send_byte(pick_data(), 1'b1);
      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] index, input logic [7:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (index)
         sfr_pkg::CSR_HEADER: cur_header = value;
         sfr_pkg::CSR_TAIL:   cur_tail = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // new header and tail, plus a write to a spare index that must not stick
   task automatic configure(input logic [7:0] header, input logic [7:0] tail);
      settle();
      write_reg(sfr_pkg::CSR_HEADER, header);
      write_reg(sfr_pkg::CSR_TAIL, tail);
      write_reg(8'($urandom_range(sfr_pkg::CSR_TAIL + 1, CSR_LAST)),
                8'($urandom_range(0, 255)));
   endtask

   // random frame: mostly well formed, some spoiled, a few cut short
   task automatic random_frame();
      int unsigned    pick;
      int unsigned    length;
      frame_kind_type kind;
      if ($urandom_range(0, 3) == 0)
         send_noise($urandom_range(1, 4));
      pick = $urandom_range(0, 19);
      if (pick == 15 || pick == 16)
         kind = FRAME_BAD_TAIL;
      else if (pick == 17 || pick == 18)
         kind = FRAME_BAD_SUM;
      else
         kind = FRAME_GOOD;
      build_frame(kind, 1'b1, 8'h00, 16'h0000);
      // a cut frame swallows whatever comes next until it is 24 bytes long
      length = (pick == 19) ? $urandom_range(2, sfr_pkg::FRAME_LEN - 1) : sfr_pkg::FRAME_LEN;
      send_frame(length, 1'b1);
      random_beats += length;
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------

   initial begin
      directed_row_type row;
      int unsigned      phase;
      logic [7:0]       value;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_valid   <= 1'b0;
      csr_index   <= 8'h00;
      csr_data    <= 8'h00;
      cur_header = sfr_pkg::HEADER_RESET;
      cur_tail   = sfr_pkg::TAIL_RESET;
      fill_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // spare index with all bits set, must leave the registers alone
      write_reg(CSR_LAST, 8'hFF);

      // directed frames
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.header != cur_header || row.tail != cur_tail)
            configure(row.header, row.tail);
         send_noise(row.noise);
         build_frame(row.kind, !row.typed, row.stop, row.word);
         send_frame(sfr_pkg::FRAME_LEN, !row.typed);
         // typed rows: a good frame reads back as its own bytes, a bad one not at all
         if (row.typed && row.kind == FRAME_GOOD)
            frame_results.push_back(sfr_pkg::result_type'({row.stop, {10{row.word}}}));
      end

      // random phases, each under its own register setting and idling mood
      phase = 0;
      while (random_beats < RANDOM_BEATS) begin
         case (phase % 5)
            0: configure(sfr_pkg::HEADER_RESET, sfr_pkg::TAIL_RESET);
            1: configure(8'h00, 8'hFF);
            2: configure(8'hFF, 8'h00);
            3: begin
               value = 8'($urandom_range(0, 255));
               configure(value, value);
            end
            default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         endcase
         source_quiet = ($urandom_range(0, 3) == 0);
         sink_quiet   = ($urandom_range(0, 3) == 0);
         repeat (4) begin
            random_frame();
            // now and then let the output side catch up completely
            if ($urandom_range(0, 15) == 0)
               wait_results_done();
         end
         phase++;
      end

      // wind down
      source_quiet = 1'b0;
      sink_quiet   = 1'b0;
      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_results.size() != 0)
         log_failure($sformatf("%0d frames never came out", frame_results.size()));

      if (miss_count == 0) begin
         $display("sensor_frame_receiver regression: pass");
      end else begin
         $display("sensor_frame_receiver regression: fail");
      end
      $finish;
   end

endmodule
